FILE: src/tbs_pkg.sv
// Shared types and constants of the texture sampler.
// No dependencies; every module of the block imports it.
package tbs_pkg;

    // Parameter defaults
    localparam int STORE_BYTES_DEF = 65536;
    localparam int COORD_FRAC_DEF  = 16;
    localparam int WEIGHT_BITS_DEF = 8;

    // Fixed field widths
    localparam int COORD_W   = 18;
    localparam int SIZE_W    = 13;
    localparam int CHAN_W    = 3;
    localparam int ADDR_IN_W = 16;
    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Texel index (y*width + x) and byte base ((index)*channels, plus headroom)
    localparam int TIDX_W = 26;
    localparam int BASE_W = 30;

    // Four neighbors, three color bytes each, two read ports per store copy
    localparam int NTAP  = 4;
    localparam int NCHAN = 3;
    localparam int NREAD = NTAP * NCHAN;
    localparam int NBANK = NREAD / 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_BILINEAR  = 2'd1,
        OP_INTENSITY = 2'd2,
        OP_NEAREST   = 2'd3
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } ctl_t;

    typedef struct packed {
        logic [ADDR_IN_W-1:0] addr;
        logic [BYTE_W-1:0]    data;
    } wr_t;

endpackage

FILE: src/bilinear_texture_sampler_unit.sv
// Texture sampler top level: byte store with bilinear and nearest sampling.
// One transaction per cycle while the result register is not blocked by out_stall (in_stall low).
// The rate is set by the store: six copies with two read ports each serve all 12 bytes.
// Reset (rst_n, asynchronous) clears the pipeline valid bits and sets width 1, height 1,
// channels 3; store contents are undefined until written and are not cleared.
module bilinear_texture_sampler_unit
    import tbs_pkg::*;
#(
    parameter int STORE_BYTES     = STORE_BYTES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [ADDR_IN_W-1:0]      byte_addr,
    input  logic [BYTE_W-1:0]         byte_value,
    input  logic signed [COORD_W-1:0] u_coord,
    input  logic signed [COORD_W-1:0] v_coord,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [VALUE_W-1:0]        red_value,
    output logic [VALUE_W-1:0]        green_value,
    output logic [VALUE_W-1:0]        blue_value,
    output logic [VALUE_W-1:0]        gray_value,
    output logic                      out_of_range,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [SIZE_W-1:0]         cfg_data
);

    localparam int AW    = $clog2(STORE_BYTES);
    localparam int NPIPE = 7;
    localparam int WSTG  = 4;

    logic [SIZE_W-1:0]      width_reg;
    logic [SIZE_W-1:0]      height_reg;
    logic [CHAN_W-1:0]      channels_reg;
    logic [SIZE_W-1:0]      wd;
    logic [SIZE_W-1:0]      ht;
    logic                   en;
    ctl_t                   ctl_reg [NPIPE];
    wr_t                    wr_reg [WSTG + 1];
    logic [SIZE_W-1:0]      ulo, uhi, vlo, vhi;
    logic [WEIGHT_BITS-1:0] wu, wv;
    logic [WEIGHT_BITS-1:0] wu_pipe_reg [WSTG];
    logic [WEIGHT_BITS-1:0] wv_pipe_reg [WSTG];
    logic [BASE_W-1:0]      base [NTAP];
    logic                   bad;
    logic                   bad6_reg;
    logic                   bad7_reg;
    logic [AW-1:0]          raddr [NREAD];
    logic [BYTE_W-1:0]      mem_q [NREAD];
    logic [BYTE_W-1:0]      blend_q [NCHAN][NTAP];
    logic [VALUE_W-1:0]     chan_val [NCHAN];
    logic                   store_we;
    logic [AW-1:0]          store_waddr;
    logic                   out_valid_reg;
    op_t                    out_op_reg;
    logic                   out_bad_reg;
    logic                   color_mode;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SIZE_W'(1);
            height_reg   <= SIZE_W'(1);
            channels_reg <= CHAN_W'(3);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:    width_reg    <= cfg_data;
                REG_HEIGHT:   height_reg   <= cfg_data;
                REG_CHANNELS: channels_reg <= cfg_data[CHAN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Zero size counts as one
    assign wd = (width_reg == '0) ? SIZE_W'(1) : width_reg;
    assign ht = (height_reg == '0) ? SIZE_W'(1) : height_reg;

    // Advance the whole pipeline unless the result register is blocked
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Control and write payload travel with the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPIPE; i++)
                ctl_reg[i] <= '{valid: 1'b0, op: OP_WRITE};
        end
        else if (en)
        begin
            ctl_reg[0] <= '{valid: in_valid, op: op_t'(op)};
            for (int i = 1; i < NPIPE; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wr_reg[0] <= '{addr: byte_addr, data: byte_value};
            for (int i = 1; i <= WSTG; i++)
                wr_reg[i] <= wr_reg[i-1];
            wu_pipe_reg[0] <= wu;
            wv_pipe_reg[0] <= wv;
            for (int i = 1; i < WSTG; i++)
            begin
                wu_pipe_reg[i] <= wu_pipe_reg[i-1];
                wv_pipe_reg[i] <= wv_pipe_reg[i-1];
            end
            bad6_reg <= bad;
            bad7_reg <= bad6_reg;
        end
    end

    // Coordinate stages
    tbs_coord #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .WEIGHT_BITS     (WEIGHT_BITS)
    ) u_coord_u (
        .clk     (clk),
        .en      (en),
        .coord   (u_coord),
        .size_m1 (wd - SIZE_W'(1)),
        .nearest (op_t'(op) == OP_NEAREST),
        .lo      (ulo),
        .hi      (uhi),
        .weight  (wu)
    );

    tbs_coord #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .WEIGHT_BITS     (WEIGHT_BITS)
    ) u_coord_v (
        .clk     (clk),
        .en      (en),
        .coord   (v_coord),
        .size_m1 (ht - SIZE_W'(1)),
        .nearest (op_t'(op) == OP_NEAREST),
        .lo      (vlo),
        .hi      (vhi),
        .weight  (wv)
    );

    // Address stages
    assign color_mode = (ctl_reg[1].op != OP_INTENSITY);

    tbs_addr #(
        .STORE_BYTES (STORE_BYTES)
    ) u_addr (
        .clk   (clk),
        .en    (en),
        .ulo   (ulo),
        .uhi   (uhi),
        .vlo   (vlo),
        .vhi   (vhi),
        .wd    (wd),
        .chans (channels_reg),
        .color (color_mode),
        .base  (base),
        .bad   (bad)
    );

    // Store access: writes land in the same stage as sample reads, keeping order
    assign store_we    = en && ctl_reg[WSTG].valid && (ctl_reg[WSTG].op == OP_WRITE)
                         && (32'(wr_reg[WSTG].addr) < 32'(STORE_BYTES));
    assign store_waddr = AW'(32'(wr_reg[WSTG].addr));

    always_comb
    begin
        for (int k = 0; k < NTAP; k++)
            for (int c = 0; c < NCHAN; c++)
                raddr[k*NCHAN + c] = AW'(base[k] + BASE_W'(c));
    end

    for (genvar j = 0; j < NBANK; j++)
    begin : g_bank
        tbs_store_bank #(
            .DEPTH (STORE_BYTES),
            .AW    (AW)
        ) u_bank (
            .clk     (clk),
            .en      (en),
            .we      (store_we),
            .waddr   (store_waddr),
            .wdata   (wr_reg[WSTG].data),
            .raddr_a (raddr[2*j]),
            .raddr_b (raddr[2*j + 1]),
            .rdata_a (mem_q[2*j]),
            .rdata_b (mem_q[2*j + 1])
        );
    end

    // Regroup read bytes by channel
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
            for (int k = 0; k < NTAP; k++)
                blend_q[c][k] = mem_q[k*NCHAN + c];
    end

    for (genvar c = 0; c < NCHAN; c++)
    begin : g_blend
        tbs_blend #(
            .WEIGHT_BITS (WEIGHT_BITS)
        ) u_blend (
            .clk   (clk),
            .en    (en),
            .q     (blend_q[c]),
            .wu    (wu_pipe_reg[WSTG-1]),
            .wv    (wv_pipe_reg[WSTG-1]),
            .value (chan_val[c])
        );
    end

    // Result register; write transactions leave no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ctl_reg[NPIPE-1].valid && (ctl_reg[NPIPE-1].op != OP_WRITE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_op_reg  <= ctl_reg[NPIPE-1].op;
            out_bad_reg <= bad7_reg;
        end
    end

    // Select result fields by operation; zero everything when out of range
    assign out_valid    = out_valid_reg;
    assign out_of_range = out_bad_reg;
    assign red_value    = (!out_bad_reg && out_op_reg != OP_INTENSITY) ? chan_val[2] : '0;
    assign green_value  = (!out_bad_reg && out_op_reg != OP_INTENSITY) ? chan_val[1] : '0;
    assign blue_value   = (!out_bad_reg && out_op_reg != OP_INTENSITY) ? chan_val[0] : '0;
    assign gray_value   = (!out_bad_reg && out_op_reg == OP_INTENSITY) ? chan_val[0] : '0;

    // Checks
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |->
        (red_value == '0 && green_value == '0 && blue_value == '0 && gray_value == '0))
        else $error("out-of-range result carries nonzero values");

    a_gray_colors: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_op_reg == OP_INTENSITY) |->
        (red_value == '0 && green_value == '0 && blue_value == '0))
        else $error("intensity result carries color values");

    a_no_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg[NPIPE-1].valid && ctl_reg[NPIPE-1].op == OP_WRITE && en) |=> !out_valid)
        else $error("write transaction produced a result");

endmodule

FILE: src/tbs_coord.sv
// One coordinate axis: clamp, scale by size minus one, split into neighbors and weight.
// Two register stages. Depends on tbs_pkg.
module tbs_coord
    import tbs_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF,
    parameter int WEIGHT_BITS     = WEIGHT_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [COORD_W-1:0]  coord,
    input  logic [SIZE_W-1:0]          size_m1,
    input  logic                       nearest,
    output logic [SIZE_W-1:0]          lo,
    output logic [SIZE_W-1:0]          hi,
    output logic [WEIGHT_BITS-1:0]     weight
);

    localparam int CW = COORD_FRAC_BITS + 1;
    localparam int RW = (CW > COORD_W - 1) ? CW : COORD_W - 1;
    localparam int SW = CW + SIZE_W;
    localparam logic [RW-1:0] ONE  = RW'(1) << COORD_FRAC_BITS;
    localparam logic [SW-1:0] HALF = SW'(1) << (COORD_FRAC_BITS - 1);

    logic [RW-1:0]              pos;
    logic [RW-1:0]              clamped;
    logic [SW-1:0]              scaled_next;
    logic [SW-1:0]              scaled_reg;
    logic                       near_reg;
    logic [COORD_FRAC_BITS-1:0] frac;
    logic [SIZE_W-1:0]          floor_v;
    logic [SIZE_W-1:0]          round_v;
    logic [WEIGHT_BITS-1:0]     wt;
    logic [SIZE_W-1:0]          lo_next;
    logic [SIZE_W-1:0]          hi_next;
    logic [WEIGHT_BITS-1:0]     weight_next;
    logic [SIZE_W-1:0]          lo_reg;
    logic [SIZE_W-1:0]          hi_reg;
    logic [WEIGHT_BITS-1:0]     weight_reg;

    // Clamp to 0..1 and scale
    always_comb
    begin
        pos         = RW'(coord[COORD_W-2:0]);
        clamped     = coord[COORD_W-1] ? '0 : ((pos > ONE) ? ONE : pos);
        scaled_next = SW'(CW'(clamped)) * SW'(size_m1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scaled_reg <= scaled_next;
            near_reg   <= nearest;
        end
    end

    // Split into floor, ceiling and weight; nearest uses the rounded point twice
    always_comb
    begin
        frac    = scaled_reg[COORD_FRAC_BITS-1:0];
        floor_v = SIZE_W'(scaled_reg >> COORD_FRAC_BITS);
        round_v = SIZE_W'((scaled_reg + HALF) >> COORD_FRAC_BITS);
        wt      = WEIGHT_BITS'({frac, {WEIGHT_BITS{1'b0}}} >> COORD_FRAC_BITS);
        if (near_reg)
        begin
            lo_next     = round_v;
            hi_next     = round_v;
            weight_next = '0;
        end
        else
        begin
            lo_next     = floor_v;
            hi_next     = floor_v + SIZE_W'(frac != '0);
            weight_next = wt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            weight_reg <= weight_next;
        end
    end

    assign lo     = lo_reg;
    assign hi     = hi_reg;
    assign weight = weight_reg;

endmodule

FILE: src/tbs_addr.sv
// Byte base addresses of the four neighbor texels and the store range check.
// Three register stages: row product, texel index, byte base. Depends on tbs_pkg.
module tbs_addr
    import tbs_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [SIZE_W-1:0]   ulo,
    input  logic [SIZE_W-1:0]   uhi,
    input  logic [SIZE_W-1:0]   vlo,
    input  logic [SIZE_W-1:0]   vhi,
    input  logic [SIZE_W-1:0]   wd,
    input  logic [CHAN_W-1:0]   chans,
    input  logic                color,
    output logic [BASE_W-1:0]   base [NTAP],
    output logic                bad
);

    logic [TIDX_W-1:0] row_lo_reg;
    logic [TIDX_W-1:0] row_hi_reg;
    logic [SIZE_W-1:0] ulo_reg;
    logic [SIZE_W-1:0] uhi_reg;
    logic              color3_reg;
    logic [TIDX_W-1:0] tidx_next [NTAP];
    logic [TIDX_W-1:0] tidx_reg [NTAP];
    logic              color4_reg;
    logic [BASE_W-1:0] base_next [NTAP];
    logic [BASE_W-1:0] base_reg [NTAP];
    logic [BASE_W-1:0] last_off;
    logic              bad_next;
    logic              bad_reg;

    // Row products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_lo_reg <= TIDX_W'(vlo) * TIDX_W'(wd);
            row_hi_reg <= TIDX_W'(vhi) * TIDX_W'(wd);
            ulo_reg    <= ulo;
            uhi_reg    <= uhi;
            color3_reg <= color;
        end
    end

    // Texel indexes in neighbor order: (lo,lo) (hi,lo) (lo,hi) (hi,hi)
    always_comb
    begin
        tidx_next[0] = row_lo_reg + TIDX_W'(ulo_reg);
        tidx_next[1] = row_lo_reg + TIDX_W'(uhi_reg);
        tidx_next[2] = row_hi_reg + TIDX_W'(ulo_reg);
        tidx_next[3] = row_hi_reg + TIDX_W'(uhi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tidx_reg   <= tidx_next;
            color4_reg <= color3_reg;
        end
    end

    // Byte bases; flag any needed byte at or past the store end
    always_comb
    begin
        last_off = color4_reg ? BASE_W'(NCHAN - 1) : '0;
        bad_next = 1'b0;
        for (int k = 0; k < NTAP; k++)
        begin
            base_next[k] = BASE_W'(tidx_reg[k]) * BASE_W'(chans);
            if ((base_next[k] + last_off) >= BASE_W'(STORE_BYTES))
                bad_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_next;
            bad_reg  <= bad_next;
        end
    end

    assign base = base_reg;
    assign bad  = bad_reg;

endmodule

FILE: src/tbs_store_bank.sv
// One copy of the texel store: one write port, two registered read ports.
// Depends on tbs_pkg.
module tbs_store_bank
    import tbs_pkg::*;
#(
    parameter int DEPTH = STORE_BYTES_DEF,
    parameter int AW    = $clog2(STORE_BYTES_DEF)
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [BYTE_W-1:0] rdata_a,
    output logic [BYTE_W-1:0] rdata_b
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_a_reg;
    logic [BYTE_W-1:0] rdata_b_reg;

    // Write and read together; one item per stage, so no same-cycle collision
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[waddr] <= wdata;
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: src/tbs_blend.sv
// Two-stage bilinear blend of one channel: horizontal lerps, then vertical lerp.
// Depends on tbs_pkg.
module tbs_blend
    import tbs_pkg::*;
#(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [BYTE_W-1:0]      q [NTAP],
    input  logic [WEIGHT_BITS-1:0] wu,
    input  logic [WEIGHT_BITS-1:0] wv,
    output logic [VALUE_W-1:0]     value
);

    localparam int WW    = WEIGHT_BITS + 1;
    localparam int RW    = BYTE_W + WW;
    localparam int FW    = RW + WW;
    localparam int SHIFT = 2 * WEIGHT_BITS - 8;
    localparam logic [WW-1:0] ONE = WW'(1) << WEIGHT_BITS;

    logic [WW-1:0]          wu_c;
    logic [WW-1:0]          wv_c;
    logic [RW-1:0]          r0_next;
    logic [RW-1:0]          r1_next;
    logic [RW-1:0]          r0_reg;
    logic [RW-1:0]          r1_reg;
    logic [WEIGHT_BITS-1:0] wv_reg;
    logic [FW-1:0]          f;
    logic [VALUE_W-1:0]     value_reg;

    // Horizontal lerps
    always_comb
    begin
        wu_c    = ONE - WW'(wu);
        r0_next = RW'(q[0]) * RW'(wu_c) + RW'(q[1]) * RW'(wu);
        r1_next = RW'(q[2]) * RW'(wu_c) + RW'(q[3]) * RW'(wu);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg <= r0_next;
            r1_reg <= r1_next;
            wv_reg <= wv;
        end
    end

    // Vertical lerp, truncate to 8 fraction bits
    always_comb
    begin
        wv_c = ONE - WW'(wv_reg);
        f    = FW'(r0_reg) * FW'(wv_c) + FW'(r1_reg) * FW'(wv_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            value_reg <= VALUE_W'(f >> SHIFT);
    end

    assign value = value_reg;

endmodule
